/* design/cursor_record_to_indexed_pixels_defines.svh */
// Assertion macros for the cursor record to indexed pixels block.
`ifndef CURSOR_RECORD_TO_INDEXED_PIXELS_DEFINES_SVH
`define CURSOR_RECORD_TO_INDEXED_PIXELS_DEFINES_SVH

`ifndef SYNTH
// same-cycle check, held off during reset
`define CRIP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// next-cycle check: pre at one edge, post at the following edge
`define CRIP_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define CRIP_ASSERT(name, prop, msg)
`define CRIP_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

/* design/crip_pkg.sv */
// Shared types and constants for the cursor record to indexed pixels block.
package crip_pkg;

    localparam int CURSOR_SIDE_DEFAULT = 16;

    // record header
    localparam logic [7:0] HEADER_DEPTH = 8'd1;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_BLACK       = 2'd0;
    localparam logic [1:0] REG_WHITE       = 2'd1;
    localparam logic [1:0] REG_GRAY        = 2'd2;
    localparam logic [1:0] REG_TRANSPARENT = 2'd3;

    localparam logic [7:0] BLACK_RESET       = 8'd0;
    localparam logic [7:0] WHITE_RESET       = 8'd63;
    localparam logic [7:0] GRAY_RESET        = 8'd14;
    localparam logic [7:0] TRANSPARENT_RESET = 8'd255;

    // queue between front and back
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QUEUE_LEVEL_W-1:0] QUEUE_FULL_LEVEL = QUEUE_LEVEL_W'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        KIND_PIXEL      = 3'd0,
        KIND_HOTSPOT    = 3'd1,
        KIND_DONE       = 3'd2,
        KIND_BAD_SIZE   = 3'd3,
        KIND_BAD_HEADER = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CMD_BAD_SIZE   = 2'd0,
        CMD_BAD_HEADER = 2'd1,
        CMD_HOTSPOT    = 2'd2,
        CMD_MASK       = 2'd3
    } cmd_t;

    // one classified request for the back end
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;      // mask byte or hotspot column
        logic [7:0] hot_y;
        logic [7:0] colour;
        logic [3:0] row;
        logic [3:0] col_base;
        logic [2:0] npix_m1;   // pixels in this byte, minus one
        logic       last;      // final record byte: done follows the pixels
    } entry_t;

    typedef struct packed {
        logic [7:0] black;
        logic [7:0] white;
        logic [7:0] gray;
        logic [7:0] transparent;
    } palette_t;

endpackage

/* design/cursor_record_to_indexed_pixels.sv */
// Top level: cursor record bytes in, hotspot, pixel and status results out.
//
// Record channel: one record byte per request (record_byte, last_byte), taken at an edge
// with record_valid high and record_stall low. Result channel: one result per request,
// taken at an edge with result_valid high and result_stall low.
// Header and colour bytes are absorbed by the front end; the hotspot byte, each mask byte
// and every error become one queued request for the back end.
// A byte's first result passes the front stage, the queue, the back end's work register
// and its result register. The back end's single result register sends one result per
// cycle unless result_stall holds it, so a mask byte yields eight pixel results (plus
// done on the final byte); header and colour bytes go one per cycle unless stalled.
// A four-entry queue absorbs bursts; record_stall rises only when it and the front
// stage are full, so the sender sees backpressure a few requests after result_stall.
// A stalled result holds its value until taken.
// Reset clears the byte position, the drop flag, the queue and all valid flags, and
// loads the palette registers with their defaults. The colour plane needs no clearing:
// each record writes it before its mask bytes read it.
// Palette registers sit on an APB port at byte addresses 0, 4, 8 and 12 and must be
// written only while the block is idle; the block itself does not enforce this.
`include "cursor_record_to_indexed_pixels_defines.svh"

module cursor_record_to_indexed_pixels #(
    parameter int CURSOR_SIDE = crip_pkg::CURSOR_SIDE_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crip_pkg::PADDR_W-1:0]  paddr,
    input  logic [crip_pkg::PDATA_W-1:0]  pwdata,
    output logic [crip_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,

    input  logic                          record_valid,
    output logic                          record_stall,
    input  logic [7:0]                    record_byte,
    input  logic                          last_byte,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [2:0]                    result_kind,
    output logic [7:0]                    pixel_value,
    output logic [3:0]                    pixel_x,
    output logic [3:0]                    pixel_y,
    output logic [7:0]                    hotspot_x,
    output logic [7:0]                    hotspot_y,
    output logic                          last_of_run
);

    // palette registers
    logic [7:0]         black_reg, white_reg, gray_reg, transparent_reg;
    logic               cfg_write;
    logic [7:0]         cfg_rd;
    crip_pkg::palette_t palette;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_reg       <= crip_pkg::BLACK_RESET;
            white_reg       <= crip_pkg::WHITE_RESET;
            gray_reg        <= crip_pkg::GRAY_RESET;
            transparent_reg <= crip_pkg::TRANSPARENT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                crip_pkg::REG_BLACK:       black_reg       <= pwdata[7:0];
                crip_pkg::REG_WHITE:       white_reg       <= pwdata[7:0];
                crip_pkg::REG_GRAY:        gray_reg        <= pwdata[7:0];
                crip_pkg::REG_TRANSPARENT: transparent_reg <= pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            crip_pkg::REG_BLACK:       cfg_rd = black_reg;
            crip_pkg::REG_WHITE:       cfg_rd = white_reg;
            crip_pkg::REG_GRAY:        cfg_rd = gray_reg;
            crip_pkg::REG_TRANSPARENT: cfg_rd = transparent_reg;
        endcase
    end

    assign prdata = {{(crip_pkg::PDATA_W - 8){1'b0}}, cfg_rd};

    assign palette.black       = black_reg;
    assign palette.white       = white_reg;
    assign palette.gray        = gray_reg;
    assign palette.transparent = transparent_reg;

    // front end -> queue -> back end
    logic                                front_push_valid;
    crip_pkg::entry_t                    front_push_data;
    logic                                q_push_ready;
    logic                                q_pop_valid;
    crip_pkg::entry_t                    q_pop_data;
    logic                                q_pop_ready;
    logic [crip_pkg::QUEUE_LEVEL_W-1:0]  q_level;

    crip_front #(
        .CURSOR_SIDE (CURSOR_SIDE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .record_byte  (record_byte),
        .last_byte    (last_byte),
        .record_valid (record_valid),
        .record_stall (record_stall),
        .push_valid   (front_push_valid),
        .push_data    (front_push_data),
        .push_ready   (q_push_ready)
    );

    crip_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_push_valid),
        .push_data  (front_push_data),
        .push_ready (q_push_ready),
        .pop_valid  (q_pop_valid),
        .pop_data   (q_pop_data),
        .pop_ready  (q_pop_ready),
        .level      (q_level)
    );

    crip_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (q_pop_valid),
        .pop_data     (q_pop_data),
        .pop_ready    (q_pop_ready),
        .palette      (palette),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (result_kind),
        .pixel_value  (pixel_value),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .hotspot_x    (hotspot_x),
        .hotspot_y    (hotspot_y),
        .last_of_run  (last_of_run)
    );

    // record side backs up only behind a pending front request
    `CRIP_ASSERT(a_stall_has_pending, record_stall |-> front_push_valid, "stall without pending request")
    `CRIP_ASSERT(a_queue_bounded, q_level <= crip_pkg::QUEUE_FULL_LEVEL, "queue level past depth")
    `CRIP_ASSERT(a_pop_nonempty, (q_pop_valid && q_pop_ready) |-> (q_level != '0), "pop from empty queue")
    `CRIP_ASSERT_NEXT(a_push_lands, (front_push_valid && q_push_ready && !(q_pop_valid && q_pop_ready)), (q_level != '0), "pushed request lost")

endmodule

/* design/crip_queue.sv */
// Small FIFO of classified requests between the front and back ends.
module crip_queue
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push_valid,
    input  crip_pkg::entry_t                      push_data,
    output logic                                  push_ready,
    output logic                                  pop_valid,
    output crip_pkg::entry_t                      pop_data,
    input  logic                                  pop_ready,
    output logic [crip_pkg::QUEUE_LEVEL_W-1:0]    level
);

    localparam int PTR_W = crip_pkg::QUEUE_PTR_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(crip_pkg::QUEUE_DEPTH - 1);

    crip_pkg::entry_t slot_reg [crip_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0]                       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]                       rd_ptr_reg, rd_ptr_next;
    logic [crip_pkg::QUEUE_LEVEL_W-1:0]     level_reg, level_next;
    logic                                   do_push, do_pop;

    assign push_ready = (level_reg != crip_pkg::QUEUE_FULL_LEVEL);
    assign pop_valid  = (level_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign level      = level_reg;

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + crip_pkg::QUEUE_LEVEL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - crip_pkg::QUEUE_LEVEL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/crip_front.sv */
// Front end: takes record bytes, checks the header and length, stores the colour plane.
module crip_front #(
    parameter int CURSOR_SIDE = crip_pkg::CURSOR_SIDE_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       record_byte,
    input  logic             last_byte,
    input  logic             record_valid,
    output logic             record_stall,
    output logic             push_valid,
    output crip_pkg::entry_t push_data,
    input  logic             push_ready
);

    localparam int ROW_BYTES    = (CURSOR_SIDE + 7) / 8;
    localparam int PLANE_BYTES  = ROW_BYTES * CURSOR_SIDE;
    localparam int RECORD_LEN   = 4 + 2 * PLANE_BYTES;
    localparam int POS_W        = $clog2(RECORD_LEN + 1);
    localparam int ADDR_W       = $clog2(PLANE_BYTES);
    localparam int ROW_W        = $clog2(CURSOR_SIDE);
    localparam int COL_W        = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int LAST_NPIX_M1 = CURSOR_SIDE - 1 - 8 * (ROW_BYTES - 1);

    localparam logic [POS_W-1:0] POS_DEPTH  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_ROW    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_COL    = POS_W'(3);
    localparam logic [POS_W-1:0] POS_COLOUR = POS_W'(4);
    localparam logic [POS_W-1:0] POS_MASK   = POS_W'(4 + PLANE_BYTES);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(RECORD_LEN - 1);
    localparam logic [POS_W-1:0] POS_END    = POS_W'(RECORD_LEN);
    localparam logic [COL_W-1:0] COL_LAST   = COL_W'(ROW_BYTES - 1);
    localparam logic [7:0]       SIDE_BYTE  = 8'(CURSOR_SIDE);

    logic [7:0] colour_mem [PLANE_BYTES];
    logic [7:0] colour_rd_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             dropping_reg, dropping_next;
    logic [7:0]       hot_row_reg, hot_row_next;
    logic [ROW_W-1:0] mrow_reg, mrow_next;
    logic [COL_W-1:0] mcol_reg, mcol_next;
    logic             s1_valid_reg, s1_valid_next;
    crip_pkg::entry_t s1_entry_reg, s1_entry_next;

    logic              accept;
    logic              load_cmd;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    assign record_stall = s1_valid_reg && !push_ready;
    assign accept       = record_valid && !record_stall;
    assign push_valid   = s1_valid_reg;
    assign wr_addr      = ADDR_W'(pos_reg - POS_COLOUR);
    assign rd_addr      = ADDR_W'(pos_reg - POS_MASK);

    always_comb
    begin
        push_data        = s1_entry_reg;
        push_data.colour = colour_rd_reg;
    end

    always_comb
    begin
        pos_next      = pos_reg;
        dropping_next = dropping_reg;
        hot_row_next  = hot_row_reg;
        mrow_next     = mrow_reg;
        mcol_next     = mcol_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        load_cmd      = 1'b0;

        s1_entry_next          = s1_entry_reg;
        s1_entry_next.cmd      = crip_pkg::CMD_BAD_SIZE;
        s1_entry_next.data     = record_byte;
        s1_entry_next.hot_y    = hot_row_reg;
        s1_entry_next.row      = 4'(mrow_reg);
        s1_entry_next.col_base = 4'({mcol_reg, 3'b000});
        s1_entry_next.npix_m1  = (mcol_reg == COL_LAST) ? 3'(LAST_NPIX_M1) : 3'd7;
        s1_entry_next.last     = last_byte;

        if (accept)
        begin
            if (dropping_reg)
            begin
                // skip to the end of the broken record
                if (last_byte)
                begin
                    dropping_next = 1'b0;
                    pos_next      = '0;
                end
            end
            else if ((last_byte && (pos_reg < POS_LAST)) || (pos_reg >= POS_END))
            begin
                load_cmd          = 1'b1;
                s1_entry_next.cmd = crip_pkg::CMD_BAD_SIZE;
                pos_next          = '0;
                dropping_next     = !last_byte;
            end
            else if (((pos_reg == '0) && (record_byte != SIDE_BYTE)) ||
                     ((pos_reg == POS_DEPTH) && (record_byte != crip_pkg::HEADER_DEPTH)))
            begin
                load_cmd          = 1'b1;
                s1_entry_next.cmd = crip_pkg::CMD_BAD_HEADER;
                pos_next          = '0;
                dropping_next     = !last_byte;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg < POS_ROW)
                begin
                    // good size or depth byte, nothing to report
                end
                else if (pos_reg == POS_ROW)
                begin
                    hot_row_next = record_byte;
                end
                else if (pos_reg == POS_COL)
                begin
                    load_cmd          = 1'b1;
                    s1_entry_next.cmd = crip_pkg::CMD_HOTSPOT;
                    mrow_next         = '0;
                    mcol_next         = '0;
                end
                else if (pos_reg < POS_MASK)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    load_cmd          = 1'b1;
                    s1_entry_next.cmd = crip_pkg::CMD_MASK;
                    mem_re            = 1'b1;
                    if (mcol_reg == COL_LAST)
                    begin
                        mcol_next = '0;
                        mrow_next = mrow_reg + ROW_W'(1);
                    end
                    else
                    begin
                        mcol_next = mcol_reg + COL_W'(1);
                    end
                    if (last_byte)
                    begin
                        pos_next = '0;
                    end
                end
            end
        end

        if (accept)
        begin
            s1_valid_next = load_cmd;
        end
        else if (push_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            dropping_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            dropping_reg <= dropping_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hot_row_reg <= hot_row_next;
        mrow_reg    <= mrow_next;
        mcol_reg    <= mcol_next;
        if (accept)
        begin
            s1_entry_reg <= s1_entry_next;
        end
    end

    // colour plane: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            colour_mem[wr_addr] <= record_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            colour_rd_reg <= colour_mem[rd_addr];
        end
    end

endmodule

/* design/crip_back.sv */
// Back end: expands queued requests into results, one per cycle unless stalled, via an output register.
module crip_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    input  crip_pkg::entry_t   pop_data,
    output logic               pop_ready,
    input  crip_pkg::palette_t palette,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [2:0]         result_kind,
    output logic [7:0]         pixel_value,
    output logic [3:0]         pixel_x,
    output logic [3:0]         pixel_y,
    output logic [7:0]         hotspot_x,
    output logic [7:0]         hotspot_y,
    output logic               last_of_run
);

    crip_pkg::entry_t work_reg;
    logic             work_valid_reg, work_valid_next;
    logic [2:0]       bit_reg, bit_next;
    logic             done_phase_reg, done_phase_next;

    logic             out_valid_reg;
    crip_pkg::kind_t  kind_reg, kind_c;
    logic [7:0]       value_reg, value_c;
    logic [3:0]       x_reg, x_c;
    logic [3:0]       y_reg, y_c;
    logic [7:0]       hx_reg, hx_c;
    logic [7:0]       hy_reg, hy_c;
    logic             lor_reg, lor_c;

    logic       out_load, step, final_step, pix_last, do_pop;
    logic [2:0] bidx;
    logic       mset, cset;

    assign out_load   = !out_valid_reg || !result_stall;
    assign step       = work_valid_reg && out_load;
    assign pix_last   = (bit_reg == work_reg.npix_m1);
    assign final_step = (work_reg.cmd != crip_pkg::CMD_MASK) || done_phase_reg ||
                        (pix_last && !work_reg.last);
    assign pop_ready  = !work_valid_reg || (step && final_step);
    assign do_pop     = pop_valid && pop_ready;

    // leftmost pixel sits in bit 7
    assign bidx = ~bit_reg;
    assign mset = work_reg.data[bidx];
    assign cset = work_reg.colour[bidx];

    always_comb
    begin
        kind_c  = crip_pkg::KIND_PIXEL;
        value_c = '0;
        x_c     = '0;
        y_c     = '0;
        hx_c    = '0;
        hy_c    = '0;
        lor_c   = 1'b0;
        unique case (work_reg.cmd)
            crip_pkg::CMD_BAD_SIZE:
            begin
                kind_c = crip_pkg::KIND_BAD_SIZE;
                lor_c  = 1'b1;
            end
            crip_pkg::CMD_BAD_HEADER:
            begin
                kind_c = crip_pkg::KIND_BAD_HEADER;
                lor_c  = 1'b1;
            end
            crip_pkg::CMD_HOTSPOT:
            begin
                kind_c = crip_pkg::KIND_HOTSPOT;
                hx_c   = work_reg.data;
                hy_c   = work_reg.hot_y;
                lor_c  = 1'b1;
            end
            crip_pkg::CMD_MASK:
            begin
                if (done_phase_reg)
                begin
                    kind_c = crip_pkg::KIND_DONE;
                    lor_c  = 1'b1;
                end
                else
                begin
                    kind_c = crip_pkg::KIND_PIXEL;
                    x_c    = work_reg.col_base + {1'b0, bit_reg};
                    y_c    = work_reg.row;
                    lor_c  = pix_last && !work_reg.last;
                    case ({mset, cset})
                        2'b00:   value_c = palette.transparent;
                        2'b01:   value_c = palette.gray;
                        2'b10:   value_c = palette.white;
                        default: value_c = palette.black;
                    endcase
                end
            end
        endcase
    end

    always_comb
    begin
        work_valid_next = work_valid_reg;
        bit_next        = bit_reg;
        done_phase_next = done_phase_reg;
        if (do_pop)
        begin
            work_valid_next = 1'b1;
            bit_next        = '0;
            done_phase_next = 1'b0;
        end
        else if (step && final_step)
        begin
            work_valid_next = 1'b0;
        end
        else if (step)
        begin
            // mask byte with pixels still to go, or its done result next
            if (pix_last)
            begin
                done_phase_next = 1'b1;
            end
            else
            begin
                bit_next = bit_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            bit_reg        <= '0;
            done_phase_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            bit_reg        <= bit_next;
            done_phase_reg <= done_phase_next;
            if (out_load)
            begin
                out_valid_reg <= step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            work_reg <= pop_data;
        end
        if (out_load)
        begin
            kind_reg  <= kind_c;
            value_reg <= value_c;
            x_reg     <= x_c;
            y_reg     <= y_c;
            hx_reg    <= hx_c;
            hy_reg    <= hy_c;
            lor_reg   <= lor_c;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_kind  = kind_reg;
    assign pixel_value  = value_reg;
    assign pixel_x      = x_reg;
    assign pixel_y      = y_reg;
    assign hotspot_x    = hx_reg;
    assign hotspot_y    = hy_reg;
    assign last_of_run  = lor_reg;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the cursor record to indexed pixels block: directed rows, then random records.
module tb;
    import crip_pkg::*;

    // Geometry of the record, as the block is built here.
    localparam int SIDE          = 16;
    localparam int ROW_BYTES     = (SIDE + 7) / 8;
    localparam int PLANE_BYTES   = ROW_BYTES * SIDE;
    localparam int RECORD_LEN    = 4 + 2 * PLANE_BYTES;
    localparam int MASK_START    = 4 + PLANE_BYTES;
    // Cycles with no request taken on either side before the run is called hung.
    // The worst honest gap is the longest sender pause plus the pipeline delay, or the
    // longest result stall; the idle settle and the register writes add to that.
    localparam int IDLE_LIMIT    = 2000;
    // Quiet cycles after the last result before touching registers or ending.
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 70;

    typedef enum {REC_GOOD, REC_LONG, REC_SHORT, REC_BAD_HEADER, REC_NOISE} rec_shape_t;

    // One result request as it leaves the block.
    typedef struct {
        kind_t      kind;
        logic [7:0] value;
        logic [3:0] x;
        logic [3:0] y;
        logic [7:0] hx;
        logic [7:0] hy;
        logic       last;
    } cursor_result_t;

    // One directed record byte; typed rows carry their single expected result.
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         typed;
        kind_t      kind;
        logic [7:0] hx;
        logic [7:0] hy;
    } directed_row_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                record_valid = 1'b0;
    logic                record_stall;
    logic [7:0]          record_byte  = 8'd0;
    logic                last_byte    = 1'b0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [2:0]          result_kind;
    logic [7:0]          pixel_value;
    logic [3:0]          pixel_x;
    logic [3:0]          pixel_y;
    logic [7:0]          hotspot_x;
    logic [7:0]          hotspot_y;
    logic                last_of_run;

    cursor_record_to_indexed_pixels #(
        .CURSOR_SIDE (SIDE)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .record_valid (record_valid),
        .record_stall (record_stall),
        .record_byte  (record_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (result_kind),
        .pixel_value  (pixel_value),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .hotspot_x    (hotspot_x),
        .hotspot_y    (hotspot_y),
        .last_of_run  (last_of_run)
    );

    always #6 clk = ~clk;

    // Predictor state: its own copy of the decoder and the palette.
    logic [6:0]     rec_pos;
    logic [7:0]     colour_mem [PLANE_BYTES];
    logic [7:0]     hot_row;
    bit             skipping;
    palette_t       pal;

    cursor_result_t pending_results [$];
    cursor_result_t want;
    directed_row_t  script [24];

    int errors        = 0;
    int idle_cycles   = 0;
    int next_gap      = 0;
    int stall_left    = 0;
    int hold          = 0;
    int counted_items = 0;
    bit tx_calm       = 1'b0;
    bit rx_calm       = 1'b0;

    function automatic void check_field(string name, int wanted, int got);
        if (wanted != got)
        begin
            $error("%s: expected %0d, got %0d", name, wanted, got);
            errors++;
        end
    endfunction

    task automatic owe_result(kind_t kind, logic [7:0] value, logic [3:0] x, logic [3:0] y,
                              logic [7:0] hx, logic [7:0] hy);
        cursor_result_t r;
        r.kind  = kind;
        r.value = value;
        r.x     = x;
        r.y     = y;
        r.hx    = hx;
        r.hy    = hy;
        r.last  = 1'b0;
        pending_results.push_back(r);
    endtask

    // Work out every result one accepted record byte causes; the final one of
    // the batch carries last_of_run.
    task automatic expand_record_byte(input logic [7:0] b, input logic l, output int added);
        cursor_result_t r;
        logic [7:0]     c;
        logic [7:0]     v;
        int             k;
        int             col;
        int             i;
        int             n0;
        n0    = pending_results.size();
        added = 0;
        // after an error, everything up to the record end is swallowed
        if (skipping)
        begin
            if (l)
            begin
                skipping = 1'b0;
                rec_pos  = '0;
            end
            return;
        end
        counted_items++;
        // length check outranks the header check
        if ((l && rec_pos < RECORD_LEN - 1) || rec_pos >= RECORD_LEN)
        begin
            owe_result(KIND_BAD_SIZE, 8'd0, 4'd0, 4'd0, 8'd0, 8'd0);
            rec_pos  = '0;
            skipping = !l;
        end
        else if ((rec_pos == 0 && b != 8'(SIDE)) || (rec_pos == 1 && b != HEADER_DEPTH))
        begin
            owe_result(KIND_BAD_HEADER, 8'd0, 4'd0, 4'd0, 8'd0, 8'd0);
            rec_pos  = '0;
            skipping = !l;
        end
        else
        begin
            if (rec_pos < 2)
            begin
                // good size or depth byte adds nothing
            end
            else if (rec_pos == 2)
            begin
                hot_row = b;
            end
            else if (rec_pos == 3)
            begin
                owe_result(KIND_HOTSPOT, 8'd0, 4'd0, 4'd0, b, hot_row);
            end
            else if (rec_pos < MASK_START)
            begin
                colour_mem[rec_pos - 4] = b;
            end
            else
            begin
                k = rec_pos - MASK_START;
                c = colour_mem[k % PLANE_BYTES];
                for (i = 0; i < 8; i++)
                begin
                    col = (k % ROW_BYTES) * 8 + i;
                    if (col >= SIDE)
                        break;
                    // leftmost pixel sits in bit 7
                    if (b[7 - i])
                        v = c[7 - i] ? pal.black : pal.white;
                    else
                        v = c[7 - i] ? pal.gray : pal.transparent;
                    owe_result(KIND_PIXEL, v, 4'(col), 4'(k / ROW_BYTES), 8'd0, 8'd0);
                end
                if (l)
                    owe_result(KIND_DONE, 8'd0, 4'd0, 4'd0, 8'd0, 8'd0);
            end
            rec_pos = l ? 7'd0 : rec_pos + 7'd1;
        end
        added = pending_results.size() - n0;
        if (added > 0)
        begin
            r      = pending_results.pop_back();
            r.last = 1'b1;
            pending_results.push_back(r);
        end
    endtask

    // Offer one record byte and hold it until taken. The gap before the next
    // request is drawn here so valid is lowered only when a gap follows.
    task automatic send_byte(input logic [7:0] b, input logic l, output int added);
        if (next_gap > 0)
            repeat (next_gap) @(posedge clk);
        record_valid <= 1'b1;
        record_byte  <= b;
        last_byte    <= l;
        do
            @(posedge clk);
        while (!(record_valid && !record_stall));
        expand_record_byte(b, l, added);
        next_gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (next_gap > 0)
            record_valid <= 1'b0;
    endtask

    // Sender holds off until every owed result has come back.
    task automatic drain_results();
        if (next_gap == 0)
            record_valid <= 1'b0;
        next_gap = 0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // APB write: setup cycle, then access until pready.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bus returns to idle between transfers
        @(posedge clk);
        case (idx)
            REG_BLACK:       pal.black       = val;
            REG_WHITE:       pal.white       = val;
            REG_GRAY:        pal.gray        = val;
            REG_TRANSPARENT: pal.transparent = val;
            default: ;
        endcase
    endtask

    // Registers change only once the block has gone quiet.
    task automatic set_palette(input logic [7:0] black, input logic [7:0] white,
                               input logic [7:0] gray, input logic [7:0] transp);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_BLACK, black);
        write_reg(REG_WHITE, white);
        write_reg(REG_GRAY, gray);
        write_reg(REG_TRANSPARENT, transp);
    endtask

    // One record of the given shape with random plane content; drain_at forces
    // a full pause after that byte.
    task automatic send_record(input rec_shape_t shape, input int drain_at);
        int         len;
        int         bad_at;
        int         i;
        int         added;
        logic [7:0] b;
        logic       l;
        tx_calm = ($urandom_range(0, 3) == 0);
        case (shape)
            REC_GOOD:       len = RECORD_LEN;
            REC_LONG:       len = RECORD_LEN + $urandom_range(1, 4);
            REC_SHORT:      len = $urandom_range(1, RECORD_LEN - 1);
            REC_BAD_HEADER: len = $urandom_range(1, 12);
            default:        len = $urandom_range(1, 8);
        endcase
        bad_at = $urandom_range(0, 1);
        for (i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (shape != REC_NOISE)
            begin
                if (i == 0)
                    b = 8'(SIDE);
                if (i == 1)
                    b = HEADER_DEPTH;
                // one flipped bit is enough to spoil size or depth
                if (shape == REC_BAD_HEADER && i == bad_at)
                    b = b ^ (8'd1 << $urandom_range(0, 7));
            end
            l = (i == len - 1) || (shape == REC_NOISE && $urandom_range(0, 5) == 0);
            send_byte(b, l, added);
            if (i == drain_at || $urandom_range(0, 199) == 0)
                drain_results();
        end
    endtask

    // Result side: compare every taken request against the oldest expectation,
    // then draw the stall before the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result_kind %0d arrived with nothing owed", result_kind);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("result_kind", int'(want.kind), result_kind);
                    check_field("pixel_value", want.value, pixel_value);
                    check_field("pixel_x", want.x, pixel_x);
                    check_field("pixel_y", want.y, pixel_y);
                    check_field("hotspot_x", want.hx, hotspot_x);
                    check_field("hotspot_y", want.hy, hotspot_y);
                    check_field("last_of_run", want.last, last_of_run);
                end
                // occasional switch into or out of a stall-free stretch
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                hold = rx_calm ? 0 : $urandom_range(0, 15);
                if (hold > 0)
                begin
                    result_stall <= 1'b1;
                    stall_left   <= hold;
                end
            end
            else if (result_stall)
            begin
                if (stall_left <= 1)
                    result_stall <= 1'b0;
                stall_left <= stall_left - 1;
            end
        end
    end

    // Watchdog: too long with no request taken on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((record_valid && !record_stall) || (result_valid && !result_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("[cursor_record_to_indexed_pixels] ERROR");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int         added;
        int         phase;
        int         i;
        rec_shape_t shape;

        // Directed rows: header errors, short records, drop behavior and
        // hotspot extremes, all under the reset palette.
        script = '{
            '{8'd15,  1'b0, 1'b1, KIND_BAD_HEADER, 8'd0,   8'd0},   // size one low
            '{8'hAA,  1'b0, 1'b0, KIND_PIXEL,      8'd0,   8'd0},   // swallowed
            '{8'h55,  1'b1, 1'b0, KIND_PIXEL,      8'd0,   8'd0},   // swallowed, ends drop
            '{8'd16,  1'b0, 1'b0, KIND_PIXEL,      8'd0,   8'd0},
            '{8'd0,   1'b0, 1'b1, KIND_BAD_HEADER, 8'd0,   8'd0},   // depth zero
            '{8'hFF,  1'b1, 1'b0, KIND_PIXEL,      8'd0,   8'd0},   // swallowed
            '{8'd16,  1'b1, 1'b1, KIND_BAD_SIZE,   8'd0,   8'd0},   // one-byte record
            '{8'd0,   1'b1, 1'b1, KIND_BAD_SIZE,   8'd0,   8'd0},   // size wins over header
            '{8'd16,  1'b0, 1'b0, KIND_PIXEL,      8'd0,   8'd0},
            '{8'd1,   1'b0, 1'b0, KIND_PIXEL,      8'd0,   8'd0},
            '{8'd2,   1'b1, 1'b1, KIND_BAD_SIZE,   8'd0,   8'd0},   // ends on hotspot row
            '{8'd16,  1'b0, 1'b0, KIND_PIXEL,      8'd0,   8'd0},
            '{8'd1,   1'b0, 1'b0, KIND_PIXEL,      8'd0,   8'd0},
            '{8'd255, 1'b0, 1'b0, KIND_PIXEL,      8'd0,   8'd0},
            '{8'd0,   1'b0, 1'b1, KIND_HOTSPOT,    8'd0,   8'd255},
            '{8'hFF,  1'b1, 1'b1, KIND_BAD_SIZE,   8'd0,   8'd0},   // ends in colour plane
            '{8'd16,  1'b0, 1'b0, KIND_PIXEL,      8'd0,   8'd0},
            '{8'd1,   1'b0, 1'b0, KIND_PIXEL,      8'd0,   8'd0},
            '{8'd0,   1'b0, 1'b0, KIND_PIXEL,      8'd0,   8'd0},
            '{8'd255, 1'b0, 1'b1, KIND_HOTSPOT,    8'd255, 8'd0},
            '{8'h00,  1'b0, 1'b0, KIND_PIXEL,      8'd0,   8'd0},
            '{8'h5A,  1'b1, 1'b1, KIND_BAD_SIZE,   8'd0,   8'd0},
            '{8'd255, 1'b0, 1'b1, KIND_BAD_HEADER, 8'd0,   8'd0},   // size all ones
            '{8'd0,   1'b1, 1'b0, KIND_PIXEL,      8'd0,   8'd0}    // swallowed, ends drop
        };

        pal.black       = BLACK_RESET;
        pal.white       = WHITE_RESET;
        pal.gray        = GRAY_RESET;
        pal.transparent = TRANSPARENT_RESET;
        rec_pos         = '0;
        hot_row         = 8'd0;
        skipping        = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 24; i++)
        begin
            send_byte(script[i].data, script[i].last, added);
            // typed rows replace the prediction with the value written above
            if (script[i].typed)
            begin
                repeat (added) void'(pending_results.pop_back());
                pending_results.push_back(cursor_result_t'{script[i].kind, 8'd0, 4'd0, 4'd0,
                                                           script[i].hx, script[i].hy, 1'b1});
            end
        end

        // Random part: three palette settings, each opening with a well-formed
        // record, then one broken one (two in the last phase), then random shapes until the phase is full.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: set_palette(8'd0, 8'd255, 8'd1, 8'd254);
                1: set_palette(8'd255, 8'd0, 8'd254, 8'd1);
                default: set_palette(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            counted_items = 0;
            // first phase pauses mid-record until the block has emptied
            send_record(REC_GOOD, (phase == 0) ? 40 : -1);
            case (phase)
                0: send_record(REC_LONG, -1);
                1: send_record(REC_SHORT, -1);
                default:
                begin
                    send_record(REC_BAD_HEADER, -1);
                    send_record(REC_NOISE, -1);
                end
            endcase
            while (counted_items < PHASE_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: shape = REC_GOOD;
                    5:             shape = REC_LONG;
                    6, 7:          shape = REC_SHORT;
                    8:             shape = REC_BAD_HEADER;
                    default:       shape = REC_NOISE;
                endcase
                send_record(shape, -1);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results still owed at the end", pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("[cursor_record_to_indexed_pixels] OK");
        else
            $display("[cursor_record_to_indexed_pixels] ERROR");
        $finish;
    end

endmodule
